// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int MaxVertices = 64;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int CntW        = VtxW + 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TSWEEP,
      ST_ROOT1,
      ST_FETCH,
      ST_LOADROW,
      ST_SCAN,
      ST_POP,
      ST_POPLD,
      ST_RD2,
      ST_CHK2,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic            last_of_run;
      logic            last_in_component;
      logic [VtxW-1:0] component;
      logic [VtxW-1:0] vertex;
   } result_type;

endpackage

// ===== hw/rtl/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Kosaraju SCC over a 64x64 adjacency bit matrix with an iterative sequencer.
// ----------------------------------------------------------------------------
// channel  dir  fields
// req_     in   tuser: opcode; tdata: row_vertex, row_edges
// rsp_     out  tdata: vertex, component; tuser: last_in_component;
//               tlast: last_of_run
// csr_     in   vertex_count
//
// Row load: one write, then a 64-row read-modify-write sweep of
// the transposed matrix through its single port.
// Run: one bit of one row is tested per cycle over both passes, except
// while a stalled rsp_ holds the second pass.
// A stalled rsp_ holds the sequencer when a new vertex must be emitted.
// Reset clears valid bits per row; no clearing pass.
module strongly_connected_components (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [5:0] row_vertex, [69:6] row_edges, zero pad
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] vertex, [11:6] component, zero pad
   output logic [0:0]  rsp_tuser,   // [0] last_in_component
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import scc_pkg::*;

   localparam int EntW = VtxW + CntW;

   logic [MaxVertices-1:0] adj_mem   [MaxVertices];
   logic [MaxVertices-1:0] trans_mem [MaxVertices];
   logic [EntW-1:0]        stack_mem [MaxVertices];
   logic [VtxW-1:0]        fin_mem   [MaxVertices];

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [CntW-1:0] i_ff, i_in;
   logic [CntW-1:0] fc_ff, fc_in;
   logic [CntW-1:0] sp_ff, sp_in;
   logic [CntW-1:0] j_ff, j_in;
   logic [VtxW-1:0] v_ff, v_in;
   logic [VtxW-1:0] comp_ff, comp_in;
   logic            pass_ff, pass_in;
   logic [VtxW-1:0] r_ff, r_in;
   logic [MaxVertices-1:0] edges_ff, edges_in;
   logic [MaxVertices-1:0] row_ff, row_in;
   logic [MaxVertices-1:0] vis_ff, vis_in;
   logic [MaxVertices-1:0] adj_vld_ff, adj_vld_in;
   logic [MaxVertices-1:0] trans_vld_ff, trans_vld_in;
   logic            pend_v_ff, pend_v_in;
   result_type      pend_ff, pend_in;
   logic            out_v_ff, out_v_in;
   result_type      out_ff, out_in;

   logic [VtxW-1:0]        rd_addr;
   logic [MaxVertices-1:0] adj_q, trans_q;
   logic                   adj_qv_ff, trans_qv_ff;
   logic [EntW-1:0]        stack_q;
   logic [VtxW-1:0]        fin_q;
   logic                   adj_we, trans_we, stack_we, fin_we;
   logic [VtxW-1:0]        trans_wa;
   logic [MaxVertices-1:0] trans_wd, trans_rowq;
   logic [EntW-1:0]        stack_wd;
   logic                   out_free;
   logic                   emit;
   logic [VtxW-1:0]        emit_v;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0, out_ff.component, out_ff.vertex};
   assign rsp_tuser  = out_ff.last_in_component;
   assign rsp_tlast  = out_ff.last_of_run;
   assign out_free   = !out_v_ff || rsp_tready;
   assign trans_rowq = trans_qv_ff ? trans_q : '0;

   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[r_in] <= edges_in;
      if (trans_we) trans_mem[trans_wa] <= trans_wd;
      if (stack_we) stack_mem[sp_ff[VtxW-1:0]] <= stack_wd;
      if (fin_we) fin_mem[fc_ff[VtxW-1:0]] <= v_ff;
      adj_q       <= adj_mem[rd_addr];
      trans_q     <= trans_mem[rd_addr];
      adj_qv_ff   <= adj_vld_ff[rd_addr];
      trans_qv_ff <= trans_vld_ff[rd_addr];
      stack_q     <= stack_mem[sp_ff[VtxW-1:0] - VtxW'(1)];
      fin_q       <= fin_mem[i_ff[VtxW-1:0] - VtxW'(1)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CntW'(MaxVertices);
         adj_vld_ff   <= '0;
         trans_vld_ff <= '0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         adj_vld_ff   <= adj_vld_in;
         trans_vld_ff <= trans_vld_in;
         pend_v_ff    <= pend_v_in;
         out_v_ff     <= out_v_in;
      end
      n_ff     <= n_in;
      i_ff     <= i_in;
      fc_ff    <= fc_in;
      sp_ff    <= sp_in;
      j_ff     <= j_in;
      v_ff     <= v_in;
      comp_ff  <= comp_in;
      pass_ff  <= pass_in;
      r_ff     <= r_in;
      edges_ff <= edges_in;
      row_ff   <= row_in;
      vis_ff   <= vis_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_we ? csr_wdata : count_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      fc_in        = fc_ff;
      sp_in        = sp_ff;
      j_in         = j_ff;
      v_in         = v_ff;
      comp_in      = comp_ff;
      pass_in      = pass_ff;
      r_in         = r_ff;
      edges_in     = edges_ff;
      row_in       = row_ff;
      vis_in       = vis_ff;
      adj_vld_in   = adj_vld_ff;
      trans_vld_in = trans_vld_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      out_v_in     = out_v_ff && !rsp_tready;
      out_in       = out_ff;
      rd_addr      = v_ff;
      adj_we       = 1'b0;
      trans_we     = 1'b0;
      stack_we     = 1'b0;
      fin_we       = 1'b0;
      trans_wa     = i_ff[VtxW-1:0] - VtxW'(1);
      trans_wd     = trans_rowq;
      trans_wd[r_ff] = edges_ff[trans_wa];
      stack_wd     = {j_ff + CntW'(1), v_ff};
      emit         = 1'b0;
      emit_v       = v_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == OP_LOAD) begin
                  r_in       = req_tdata[VtxW-1:0];
                  edges_in   = req_tdata[VtxW +: MaxVertices];
                  adj_we     = 1'b1;
                  adj_vld_in[r_in] = 1'b1;
                  i_in       = '0;
                  state_in   = ST_TSWEEP;
               end else begin
                  n_in     = (count_ff > CntW'(MaxVertices)) ? CntW'(MaxVertices) : count_ff;
                  vis_in   = '0;
                  fc_in    = '0;
                  i_in     = '0;
                  pass_in  = 1'b0;
                  comp_in  = '0;
                  if (n_in != '0) state_in = ST_ROOT1;
               end
            end
         end
         ST_TSWEEP: begin
            rd_addr = i_ff[VtxW-1:0];
            if (i_ff != '0) begin
               trans_we = 1'b1;
               trans_vld_in[trans_wa] = 1'b1;
            end
            i_in = i_ff + CntW'(1);
            if (i_ff == CntW'(MaxVertices)) state_in = ST_IDLE;
         end
         ST_ROOT1: begin
            if (i_ff == n_ff) begin
               vis_in   = '0;
               pass_in  = 1'b1;
               i_in     = fc_ff;
               state_in = ST_RD2;
            end else if (vis_ff[i_ff[VtxW-1:0]]) begin
               i_in = i_ff + CntW'(1);
            end else begin
               v_in     = i_ff[VtxW-1:0];
               j_in     = '0;
               sp_in    = '0;
               vis_in[v_in] = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOADROW;
         ST_LOADROW: begin
            row_in   = pass_ff ? trans_rowq : (adj_qv_ff ? adj_q : '0);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (j_ff == n_ff) begin
               if (!pass_ff) begin
                  fin_we = 1'b1;
                  fc_in  = fc_ff + CntW'(1);
               end
               if (sp_ff != '0) begin
                  state_in = ST_POP;
               end else if (pass_ff) begin
                  pend_in.last_in_component = 1'b1;
                  comp_in  = comp_ff + VtxW'(1);
                  state_in = ST_RD2;
               end else begin
                  state_in = ST_ROOT1;
               end
            end else if (row_ff[j_ff[VtxW-1:0]] && !vis_ff[j_ff[VtxW-1:0]]) begin
               if (!pass_ff || out_free) begin
                  emit     = pass_ff;
                  emit_v   = j_ff[VtxW-1:0];
                  stack_we = 1'b1;
                  sp_in    = sp_ff + CntW'(1);
                  v_in     = j_ff[VtxW-1:0];
                  j_in     = '0;
                  vis_in[v_in] = 1'b1;
                  state_in = ST_FETCH;
               end
            end else begin
               j_in = j_ff + CntW'(1);
            end
         end
         ST_POP: state_in = ST_POPLD;
         ST_POPLD: begin
            v_in     = stack_q[VtxW-1:0];
            j_in     = stack_q[EntW-1:VtxW];
            sp_in    = sp_ff - CntW'(1);
            state_in = ST_FETCH;
         end
         ST_RD2: begin
            state_in = (i_ff == '0) ? ST_FLUSH : ST_CHK2;
         end
         ST_CHK2: begin
            if (vis_ff[fin_q]) begin
               i_in     = i_ff - CntW'(1);
               state_in = ST_RD2;
            end else if (out_free) begin
               emit     = 1'b1;
               emit_v   = fin_q;
               v_in     = fin_q;
               j_in     = '0;
               sp_in    = '0;
               vis_in[v_in] = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_in   = pend_ff;
               out_in.last_in_component = 1'b1;
               out_in.last_of_run       = 1'b1;
               out_v_in  = 1'b1;
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         if (pend_v_ff) begin
            out_in   = pend_ff;
            out_v_in = 1'b1;
         end
         pend_v_in = 1'b1;
         pend_in   = '{last_of_run: 1'b0, last_in_component: 1'b0,
                       component: comp_ff, vertex: emit_v};
      end
   end

endmodule

// ===== hw/rtl/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks for strongly_connected_components, bound to the top.
// ----------------------------------------------------------------------------
module scc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import scc_pkg::*;

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("outputs not idle after reset");

   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == OP_LOAD) |=> !req_tready)
      else $error("ready right after a load transfer");

   a_last_ends_comp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("run end without component end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_scoreboard
// Watches the request, response and register ports of the strongly connected
// components block. It keeps its own copy of the adjacency matrix and the
// vertex count, and predicts the component walk for every accepted run
// transfer. Each response transfer is compared field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module scc_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import scc_pkg::*;

   logic [63:0] adj_rows [MaxVertices];
   logic [63:0] tr_rows  [MaxVertices];
   bit          seen     [MaxVertices];
   logic [5:0]  fin_seq  [MaxVertices];
   logic [5:0]  stk_vtx  [MaxVertices];
   logic [6:0]  stk_next [MaxVertices];
   int          fin_cnt;
   int          depth;
   logic [6:0]  vcount;
   result_type  order_q [$];

   assign pending = order_q.size();

   function automatic void mark(int v, bit emit, int comp);
      result_type r;
      seen[v] = 1'b1;
      if (emit) begin
         r = '0;
         r.vertex = v[5:0];
         r.component = comp[5:0];
         order_q.push_back(r);
      end
      stk_vtx[depth] = v[5:0];
      stk_next[depth] = '0;
      depth++;
   endfunction

   function automatic void walk(int root, bit second, int comp, int n);
      int v;
      int j;
      bit found;
      logic [63:0] row;
      depth = 0;
      mark(root, second, comp);
      while (depth > 0) begin
         v = stk_vtx[depth-1];
         j = stk_next[depth-1];
         row = second ? tr_rows[v] : adj_rows[v];
         found = 0;
         while (j < n && !found) begin
            if (row[j] && !seen[j]) found = 1;
            else j++;
         end
         if (found) begin
            stk_next[depth-1] = 7'(j + 1);
            mark(j, second, comp);
         end else begin
            depth--;
            if (!second) begin
               fin_seq[fin_cnt] = v[5:0];
               fin_cnt++;
            end
         end
      end
   endfunction

   function automatic void predict_components();
      int n;
      int comp;
      int run_start;
      int size_prev;
      result_type r;
      n = (vcount > MaxVertices) ? MaxVertices : int'(vcount);
      if (n == 0) return;
      foreach (seen[i]) seen[i] = 0;
      fin_cnt = 0;
      for (int i = 0; i < n; i++)
         if (!seen[i]) walk(i, 1'b0, 0, n);
      foreach (seen[i]) seen[i] = 0;
      comp = 0;
      run_start = order_q.size();
      for (int i = fin_cnt; i > 0; i--) begin
         if (fin_seq[i-1] < n && !seen[fin_seq[i-1]]) begin
            size_prev = order_q.size();
            walk(fin_seq[i-1], 1'b1, comp, n);
            if (order_q.size() > size_prev) begin
               r = order_q.pop_back();
               r.last_in_component = 1'b1;
               order_q.push_back(r);
            end
            comp++;
         end
      end
      if (order_q.size() > run_start) begin
         r = order_q.pop_back();
         r.last_of_run = 1'b1;
         order_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      logic [5:0]  rv;
      logic [63:0] edges;
      result_type  got;
      result_type  want;
      if (reset) begin
         foreach (adj_rows[i]) begin
            adj_rows[i] = '0;
            tr_rows[i] = '0;
         end
         vcount = 7'd64;
         order_q.delete();
         errors = 0;
      end else begin
         if (csr_we) vcount = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_LOAD) begin
               rv = req_tdata[5:0];
               edges = req_tdata[69:6];
               adj_rows[rv] = edges;
               for (int i = 0; i < MaxVertices; i++) tr_rows[i][rv] = edges[i];
            end else begin
               predict_components();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.vertex = rsp_tdata[5:0];
            got.component = rsp_tdata[11:6];
            got.last_in_component = rsp_tuser[0];
            got.last_of_run = rsp_tlast;
            if (order_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected transfer: v%0d c%0d lic %0b lor %0b",
                           got.vertex, got.component, got.last_in_component,
                           got.last_of_run);
            end else begin
               want = order_q.pop_front();
               if (got.vertex != want.vertex || got.component != want.component ||
                   got.last_in_component != want.last_in_component ||
                   got.last_of_run != want.last_of_run) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp v%0d c%0d lic %0b lor %0b,",
                               " got v%0d c%0d lic %0b lor %0b"},
                              want.vertex, want.component, want.last_in_component,
                              want.last_of_run, got.vertex, got.component,
                              got.last_in_component, got.last_of_run);
               end
            end
         end
      end
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the strongly connected components block: directed graphs with
// extreme rows and counts, then random graphs over many vertex counts, with
// random idle bursts on both sides, a long response stall and drained phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import scc_pkg::*;

   localparam int WatchdogLimit = 60000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [6:0]  csr_wdata;
   int          errors;
   int          pending;
   bit          gaps_on;
   bit          hold_req;
   int          items;
   int          quiet;
   int          n;

   strongly_connected_components i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   scc_scoreboard i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchdogLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            for (int k = 0; k < 2000; k++) @(negedge clock);
            hold_req = 0;
         end else if (gaps_on && $urandom_range(5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send(logic op, logic [5:0] rv, logic [63:0] edges);
      @(negedge clock);
      if (gaps_on && $urandom_range(4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {2'b00, edges, rv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (200) @(negedge clock);
   endtask

   task automatic set_count(logic [6:0] value);
      drain();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [63:0] rand_edges(int cnt);
      logic [63:0] e;
      logic [63:0] mask;
      e = {$urandom, $urandom};
      case ($urandom_range(3))
         0: e = e & {$urandom, $urandom};
         1: e = e & {$urandom, $urandom} & {$urandom, $urandom};
         default: ;
      endcase
      mask = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 1);
      if ($urandom_range(7) != 0) e = e & mask;
      return e;
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOAD;
      csr_we = 1'b0;
      csr_wdata = '0;
      gaps_on = 0;
      hold_req = 0;
      items = 0;
      quiet = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty graph at reset count, extreme rows, count corners
      send(OP_RUN, 6'd0, '0);
      send(OP_LOAD, 6'd0, '1);
      send(OP_LOAD, 6'd63, '1);
      send(OP_LOAD, 6'd62, 64'h8000_0000_0000_0000);
      send(OP_RUN, 6'd0, '0);
      set_count(7'd0);
      send(OP_RUN, 6'd0, '0);
      set_count(7'd127);
      send(OP_RUN, 6'd0, '0);
      set_count(7'd1);
      send(OP_RUN, 6'd0, '0);
      set_count(7'd5);
      send(OP_LOAD, 6'd1, 64'hAAAA_AAAA_AAAA_AAA5);
      send(OP_LOAD, 6'd2, 64'h5555_5555_5555_5559);
      send(OP_LOAD, 6'd3, 64'h0000_0000_0000_0012);
      send(OP_LOAD, 6'd40, 64'h0000_0000_0000_001F);
      send(OP_LOAD, 6'd4, 64'hFFFF_FFFF_FFFF_FFE8);
      send(OP_RUN, 6'd0, '0);
      for (int i = 0; i < 64; i++) send(OP_LOAD, i[5:0], '0);
      send(OP_RUN, 6'd0, '0);

      // long response stall while requests keep coming
      set_count(7'd12);
      gaps_on = 1;
      for (int i = 0; i < 12; i++) send(OP_LOAD, i[5:0], rand_edges(12));
      hold_req = 1;
      send(OP_RUN, 6'd0, '0);
      for (int i = 0; i < 4; i++) send(OP_LOAD, i[5:0], rand_edges(12));
      send(OP_RUN, 6'd0, '0);

      while (items < 300) begin
         case ($urandom_range(9))
            0: n = 64;
            1: n = $urandom_range(65, 127);
            2: n = 1;
            3: n = 2;
            default: n = $urandom_range(3, 10);
         endcase
         if (items > 250) gaps_on = 0;
         set_count(n[6:0]);
         for (int i = 0; i < ((n > 64) ? 3 : n); i++)
            send(OP_LOAD, 6'((n > 64) ? $urandom_range(63) : i), rand_edges(n));
         repeat ($urandom_range(2)) send(OP_LOAD, 6'($urandom_range(63)), rand_edges(64));
         send(OP_RUN, 6'(0), '0);
         if ($urandom_range(2) == 0) send(OP_RUN, 6'(0), '0);
      end

      drain();
      if (errors == 0 && pending == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
